FILE: src/met_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and fixed-point helpers for the mandelbrot escape-time block
// no dependencies; used by met_cell, met_mul_chain and mandelbrot_escape_time

package met_pkg;

  // number format: signed fixed point, 8 integer bits (sign included)
  localparam int FracBits = 32;
  localparam int FxW      = 8 + FracBits;

  // field and register widths
  localparam int ColW     = 12;
  localparam int RowW     = 11;
  localparam int StepW    = 33;
  localparam int StepFrac = 32;
  localparam int CountW   = 8;
  localparam int TotW     = 40;

  // configuration port
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = StepW;
  localparam logic [CfgIdxW-1:0] CfgPixelStep = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMaxIter   = CfgIdxW'(1);

  localparam logic [StepW-1:0]  StepReset    = StepW'(4194304);
  localparam logic [CountW-1:0] MaxIterReset = CountW'(255);

  // index scaling: step product aligned to FracBits fraction bits
  localparam int ShiftLeft  = (FracBits >= StepFrac) ? FracBits - StepFrac : 0;
  localparam int ShiftRight = (FracBits <  StepFrac) ? StepFrac - FracBits : 0;
  localparam int ScaleW     = ColW + StepW + ShiftLeft;

  // multiplier chain: magnitude product split into digits, one digit per cell
  localparam int Cells   = 4;
  localparam int DigitW  = (FxW + Cells - 1) / Cells;
  localparam int PadW    = Cells * DigitW;
  localparam int ProdW   = 2 * FxW;
  localparam int FullW   = ProdW - FracBits;
  localparam int MulLat  = Cells + 2;

  localparam int TagW = 2;
  localparam logic [TagW-1:0] TagRr = TagW'(0);
  localparam logic [TagW-1:0] TagIi = TagW'(1);
  localparam logic [TagW-1:0] TagRi = TagW'(2);

  typedef logic signed [FxW-1:0] fx_t;

  localparam logic [FxW-1:0] FxMaxMag = {1'b0, {(FxW-1){1'b1}}};
  localparam fx_t FxMax  = fx_t'(FxMaxMag);
  localparam fx_t FxMin  = fx_t'({1'b1, {(FxW-1){1'b0}}});
  localparam fx_t FxOne  = fx_t'({1'b1, {FracBits{1'b0}}});
  localparam fx_t FxTwo  = fx_t'({2'b10, {FracBits{1'b0}}});
  localparam fx_t FxFour = fx_t'({3'b100, {FracBits{1'b0}}});

  localparam logic [FullW-1:0] MulPosLim = FullW'(FxMaxMag);
  localparam logic [FullW-1:0] MulNegLim = FullW'(FxMaxMag) + FullW'(1);

  typedef struct packed {
    logic [ColW-1:0] column_index;
    logic [RowW-1:0] row_index;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] iteration_count;
    logic [TotW-1:0]   iteration_total;
  } out_item_t;

  typedef struct packed {
    logic            vld;
    logic [TagW-1:0] tag;
    fx_t             a;
    fx_t             b;
  } mul_req_t;

  typedef struct packed {
    logic            vld;
    logic [TagW-1:0] tag;
    fx_t             p;
  } mul_rsp_t;

  // data handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             neg;
    logic [TagW-1:0]  tag;
    logic [FxW-1:0]   a_mag;
    logic [PadW-1:0]  b_mag;
    logic [ProdW-1:0] acc;
  } lane_t;

  function automatic fx_t fx_add_sat(fx_t a, fx_t b);
    logic signed [FxW:0] s;
    s = a + b;
    if (s[FxW] != s[FxW-1]) begin
      return s[FxW] ? FxMin : FxMax;
    end
    return fx_t'(s[FxW-1:0]);
  endfunction

  function automatic fx_t fx_sub_sat(fx_t a, fx_t b);
    logic signed [FxW:0] s;
    s = a - b;
    if (s[FxW] != s[FxW-1]) begin
      return s[FxW] ? FxMin : FxMax;
    end
    return fx_t'(s[FxW-1:0]);
  endfunction

endpackage

FILE: src/met_cell.sv
`timescale 1ns / 1ps
// one digit cell of the multiplier chain: horner step acc = acc * 2^digit + a * top digit of b
// depends on met_pkg

module met_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  met_pkg::lane_t lane_in,
  output met_pkg::lane_t lane_out
);

  met_pkg::lane_t lane_r;
  met_pkg::lane_t lane_nxt;
  logic [met_pkg::FxW+met_pkg::DigitW-1:0] pp;

  always_comb begin
    lane_nxt       = lane_in;
    pp             = lane_in.a_mag * lane_in.b_mag[met_pkg::PadW-1 -: met_pkg::DigitW];
    lane_nxt.acc   = (lane_in.acc << met_pkg::DigitW) + met_pkg::ProdW'(pp);
    lane_nxt.b_mag = lane_in.b_mag << met_pkg::DigitW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= '0;
    end else begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

FILE: src/met_mul_chain.sv
`timescale 1ns / 1ps
// pipelined fixed-point multiplier: sign/magnitude front, a row of met_cell, saturating back end
// depends on met_pkg and met_cell

module met_mul_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  met_pkg::mul_req_t req,
  output met_pkg::mul_rsp_t rsp
);

  met_pkg::lane_t    front_r;
  met_pkg::lane_t    front_nxt;
  met_pkg::lane_t    lane [0:met_pkg::Cells];
  met_pkg::mul_rsp_t rsp_r;
  met_pkg::mul_rsp_t rsp_nxt;
  logic [met_pkg::FullW-1:0] full;

  function automatic logic [met_pkg::FxW-1:0] fx_mag(met_pkg::fx_t v);
    return v[met_pkg::FxW-1] ? met_pkg::FxW'(-v) : met_pkg::FxW'(v);
  endfunction

  always_comb begin
    front_nxt       = '0;
    front_nxt.vld   = req.vld;
    front_nxt.tag   = req.tag;
    front_nxt.neg   = req.a[met_pkg::FxW-1] ^ req.b[met_pkg::FxW-1];
    front_nxt.a_mag = fx_mag(req.a);
    front_nxt.b_mag = met_pkg::PadW'(fx_mag(req.b));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
    end else begin
      front_r <= front_nxt;
    end
  end

  assign lane[0] = front_r;

  for (genvar k = 0; k < met_pkg::Cells; k++) begin : g_cell
    met_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lane_in  (lane[k]),
      .lane_out (lane[k+1])
    );
  end

  // drop fraction bits (magnitude truncates toward zero), saturate, apply sign
  always_comb begin
    full        = lane[met_pkg::Cells].acc[met_pkg::ProdW-1:met_pkg::FracBits];
    rsp_nxt.vld = lane[met_pkg::Cells].vld;
    rsp_nxt.tag = lane[met_pkg::Cells].tag;
    if (lane[met_pkg::Cells].neg) begin
      if (full > met_pkg::MulNegLim) begin
        rsp_nxt.p = met_pkg::FxMin;
      end else begin
        rsp_nxt.p = met_pkg::fx_t'(met_pkg::FxW'(0) - full[met_pkg::FxW-1:0]);
      end
    end else begin
      if (full > met_pkg::MulPosLim) begin
        rsp_nxt.p = met_pkg::FxMax;
      end else begin
        rsp_nxt.p = met_pkg::fx_t'(full[met_pkg::FxW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_r <= '0;
    end else begin
      rsp_r <= rsp_nxt;
    end
  end

  assign rsp = rsp_r;

  a_req_returns: assert property (@(posedge clk) disable iff (!rst_n)
    req.vld |-> ##(met_pkg::MulLat) rsp.vld)
    else $error("multiplier request did not come out after the chain latency");

  a_tag_kept: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld |-> rsp.tag == $past(req.tag, met_pkg::MulLat))
    else $error("multiplier result carries the wrong tag");

  a_square_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld && $past(req.a == req.b, met_pkg::MulLat) |-> !rsp.p[met_pkg::FxW-1])
    else $error("square came out negative");

endmodule

FILE: src/mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// top level of the mandelbrot escape-time block: control sequencer, orbit registers, running total
// depends on met_pkg and met_mul_chain

// pulse start while busy is low to hand over one pixel (column and row index). the block maps it to
// c = (column * pixel_step - 2) + i * (row * pixel_step - 1) in signed fixed point with 8 integer
// and 32 fraction bits, runs z = z*z + c from zero and returns, on out_strobe for exactly one
// cycle, the number of iterations that stayed inside |z|^2 < 4 (capped at max_iterations) and a
// running total of counts since reset that saturates at 2^40 - 1. the receiver cannot stall:
// out_item is valid only in the strobe cycle and must be taken then. the block works on one pixel
// at a time; busy drops in the cycle the result is shown, so the next start can be accepted in
// that same cycle. the iteration time is set by the one shared multiplier, a chain of four digit
// cells through which each iteration sends its three products (zr^2, zi^2, 2*zr*zi) back to
// back. the configuration port (index 0 pixel_step, index 1 max_iterations, other indexes
// ignored) is ready only while busy is low; write it between pixels

module mandelbrot_escape_time (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  met_pkg::in_item_t                in_item,
  output logic                             out_strobe,
  output met_pkg::out_item_t               out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [met_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [met_pkg::CfgDataW-1:0]     cfg_data
);

  // sequencer states
  localparam int StW = 4;
  localparam logic [StW-1:0] StIdle   = StW'(0);
  localparam logic [StW-1:0] StScale  = StW'(1);
  localparam logic [StW-1:0] StOrigin = StW'(2);
  localparam logic [StW-1:0] StUpdate = StW'(3);
  localparam logic [StW-1:0] StIssRr  = StW'(4);
  localparam logic [StW-1:0] StIssIi  = StW'(5);
  localparam logic [StW-1:0] StIssRi  = StW'(6);
  localparam logic [StW-1:0] StWait   = StW'(7);
  localparam logic [StW-1:0] StCheck  = StW'(8);
  localparam logic [StW-1:0] StOutput = StW'(9);

  logic [StW-1:0] state_r, state_nxt;

  // configuration registers
  logic [met_pkg::StepW-1:0]  step_r, step_nxt;
  logic [met_pkg::CountW-1:0] max_iter_r, max_iter_nxt;

  // pixel and orbit state
  logic [met_pkg::ColW-1:0]   col_r, col_nxt;
  logic [met_pkg::RowW-1:0]   row_r, row_nxt;
  met_pkg::fx_t               sr_r, sr_nxt;
  met_pkg::fx_t               si_r, si_nxt;
  met_pkg::fx_t               cr_r, cr_nxt;
  met_pkg::fx_t               ci_r, ci_nxt;
  met_pkg::fx_t               zr_r, zr_nxt;
  met_pkg::fx_t               zi_r, zi_nxt;
  met_pkg::fx_t               prr_r, prr_nxt;
  met_pkg::fx_t               pii_r, pii_nxt;
  met_pkg::fx_t               pri_r, pri_nxt;
  logic [met_pkg::CountW-1:0] count_r, count_nxt;
  logic [met_pkg::TotW-1:0]   total_r, total_nxt;

  // result register
  logic                       out_strobe_r, out_strobe_nxt;
  met_pkg::out_item_t         out_item_r, out_item_nxt;

  // shared multiplier
  met_pkg::mul_req_t          mul_req;
  met_pkg::mul_rsp_t          mul_rsp;

  // combinational helpers
  met_pkg::fx_t               mag_sq;
  logic [met_pkg::CountW-1:0] count_inc;
  logic [met_pkg::TotW:0]     total_sum;
  logic                       cfg_xfer;

  // index * step, aligned to the fixed-point fraction and clipped to the top value
  function automatic met_pkg::fx_t scale_index(logic [met_pkg::ColW-1:0]  idx,
                                               logic [met_pkg::StepW-1:0] step);
    logic [met_pkg::ColW+met_pkg::StepW-1:0] raw;
    logic [met_pkg::ScaleW-1:0]              sh;
    raw = idx * step;
    sh  = (met_pkg::ScaleW'(raw) << met_pkg::ShiftLeft) >> met_pkg::ShiftRight;
    if (sh > met_pkg::ScaleW'(met_pkg::FxMaxMag)) begin
      return met_pkg::FxMax;
    end
    return met_pkg::fx_t'(sh[met_pkg::FxW-1:0]);
  endfunction

  met_mul_chain u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign busy      = (state_r != StIdle);
  assign cfg_ready = !busy;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    max_iter_nxt   = max_iter_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    sr_nxt         = sr_r;
    si_nxt         = si_r;
    cr_nxt         = cr_r;
    ci_nxt         = ci_r;
    zr_nxt         = zr_r;
    zi_nxt         = zi_r;
    prr_nxt        = prr_r;
    pii_nxt        = pii_r;
    pri_nxt        = pri_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mul_req        = '0;

    // |z|^2 from the two squares of the newest z
    mag_sq    = met_pkg::fx_add_sat(prr_r, pii_r);
    count_inc = count_r + met_pkg::CountW'(1);
    total_sum = {1'b0, total_r} + (met_pkg::TotW + 1)'(count_r);

    // register writes, taken only between pixels
    if (cfg_xfer) begin
      case (cfg_index)
        met_pkg::CfgPixelStep: step_nxt     = cfg_data;
        met_pkg::CfgMaxIter:   max_iter_nxt = cfg_data[met_pkg::CountW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      StIdle: begin
        if (start) begin
          col_nxt   = in_item.column_index;
          row_nxt   = in_item.row_index;
          state_nxt = StScale;
        end
      end
      StScale: begin
        sr_nxt    = scale_index(col_r, step_r);
        si_nxt    = scale_index(met_pkg::ColW'(row_r), step_r);
        state_nxt = StOrigin;
      end
      StOrigin: begin
        // orbit starts at zero, so its products are zero as well
        cr_nxt    = met_pkg::fx_sub_sat(sr_r, met_pkg::FxTwo);
        ci_nxt    = met_pkg::fx_sub_sat(si_r, met_pkg::FxOne);
        zr_nxt    = '0;
        zi_nxt    = '0;
        prr_nxt   = '0;
        pii_nxt   = '0;
        pri_nxt   = '0;
        count_nxt = '0;
        state_nxt = (max_iter_r == '0) ? StOutput : StUpdate;
      end
      StUpdate: begin
        // z = z*z + c from the products of the previous z
        zr_nxt    = met_pkg::fx_add_sat(met_pkg::fx_sub_sat(prr_r, pii_r), cr_r);
        zi_nxt    = met_pkg::fx_add_sat(pri_r, ci_r);
        state_nxt = StIssRr;
      end
      StIssRr: begin
        mul_req   = '{vld: 1'b1, tag: met_pkg::TagRr, a: zr_r, b: zr_r};
        state_nxt = StIssIi;
      end
      StIssIi: begin
        mul_req   = '{vld: 1'b1, tag: met_pkg::TagIi, a: zi_r, b: zi_r};
        state_nxt = StIssRi;
      end
      StIssRi: begin
        mul_req   = '{vld: 1'b1, tag: met_pkg::TagRi,
                      a: met_pkg::fx_add_sat(zr_r, zr_r), b: zi_r};
        state_nxt = StWait;
      end
      StWait: begin
        // products come back in issue order, the cross term last
        if (mul_rsp.vld) begin
          case (mul_rsp.tag)
            met_pkg::TagRr: prr_nxt = mul_rsp.p;
            met_pkg::TagIi: pii_nxt = mul_rsp.p;
            met_pkg::TagRi: begin
              pri_nxt   = mul_rsp.p;
              state_nxt = StCheck;
            end
            default: ;
          endcase
        end
      end
      StCheck: begin
        if (mag_sq >= met_pkg::FxFour) begin
          state_nxt = StOutput;
        end else begin
          count_nxt = count_inc;
          state_nxt = (count_inc == max_iter_r) ? StOutput : StUpdate;
        end
      end
      StOutput: begin
        // saturating running total
        if (total_sum[met_pkg::TotW]) begin
          total_nxt = '1;
        end else begin
          total_nxt = total_sum[met_pkg::TotW-1:0];
        end
        out_item_nxt.iteration_count = count_r;
        out_item_nxt.iteration_total = total_nxt;
        out_strobe_nxt               = 1'b1;
        state_nxt                    = StIdle;
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= StIdle;
      step_r       <= met_pkg::StepReset;
      max_iter_r   <= met_pkg::MaxIterReset;
      zr_r         <= '0;
      zi_r         <= '0;
      count_r      <= '0;
      total_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      max_iter_r   <= max_iter_nxt;
      zr_r         <= zr_nxt;
      zi_r         <= zi_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    sr_r       <= sr_nxt;
    si_r       <= si_nxt;
    cr_r       <= cr_nxt;
    ci_r       <= ci_nxt;
    prr_r      <= prr_nxt;
    pii_r      <= pii_nxt;
    pri_r      <= pri_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // the result cycle is always an idle cycle, so a new pixel can start under it
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while a pixel is still in work");

  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.iteration_count <= max_iter_r)
    else $error("iteration count above the configured cap");

  a_total_covers_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_item.iteration_total >= met_pkg::TotW'(out_item.iteration_count))
    else $error("running total smaller than the count it includes");

  a_no_stray_product: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.vld |-> state_r == StWait)
    else $error("multiplier result arrived outside the wait state");

endmodule

FILE: verif/tb_mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// self-checking testbench for mandelbrot_escape_time: directed table, then randomized phases
// depends on met_pkg and the mandelbrot_escape_time rtl; needs nothing else to run

module tb_mandelbrot_escape_time;

  // package names used here
  localparam int FracBits = met_pkg::FracBits;
  localparam int ColW     = met_pkg::ColW;
  localparam int RowW     = met_pkg::RowW;
  localparam int StepW    = met_pkg::StepW;
  localparam int StepFrac = met_pkg::StepFrac;
  localparam int CountW   = met_pkg::CountW;
  localparam int TotW     = met_pkg::TotW;
  localparam int CfgIdxW  = met_pkg::CfgIdxW;
  localparam int CfgDataW = met_pkg::CfgDataW;
  localparam int ProdW    = met_pkg::ProdW;

  localparam logic [CfgIdxW-1:0] CfgPixelStep = met_pkg::CfgPixelStep;
  localparam logic [CfgIdxW-1:0] CfgMaxIter   = met_pkg::CfgMaxIter;
  localparam logic [StepW-1:0]   StepReset    = met_pkg::StepReset;
  localparam logic [CountW-1:0]  MaxIterReset = met_pkg::MaxIterReset;

  typedef met_pkg::in_item_t  in_item_t;
  typedef met_pkg::out_item_t out_item_t;

  // fixed-point limits in 64-bit form for the escape-time predictor
  localparam longint FxHi   = longint'(met_pkg::FxMax);
  localparam longint FxLo   = longint'(met_pkg::FxMin);
  localparam longint FxUnit = longint'(met_pkg::FxOne);

  localparam logic [TotW-1:0]    TotTop   = {TotW{1'b1}};
  localparam logic [StepW-1:0]   StepUnit = StepW'(1) << StepFrac;  // step of 1.0
  localparam logic [CfgIdxW-1:0] CfgSpare   = CfgIdxW'(2);          // first index with no register
  localparam logic [CfgIdxW-1:0] CfgIdxLast = {CfgIdxW{1'b1}};
  localparam int IdxTop = (1 << CfgIdxW) - 1;

  localparam int NoPin       = -1;     // count comes from the predictor alone
  localparam int Phases      = 10;
  localparam int PhaseItems  = 210;
  localparam int DeepItems   = 60;     // the phase at full cap and fine step is slow
  localparam int StallLimit  = 30000;  // ~10x one full 255-iteration pixel plus a gap
  localparam int TailCycles  = 40;

  typedef enum logic {RowPixel, RowWrite} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   value;
    logic [ColW-1:0]       col;
    logic [RowW-1:0]       row;
    int                    pin;
  } plan_row_t;

  localparam int PlanRows = 29;

  // directed part: counts are pinned only where they are obvious by hand
  plan_row_t plan [PlanRows] = '{
    // reset config: step 1/1024, cap 255
    '{RowPixel, '0, '0, 12'd0,    11'd0,    0},      // c = -2 - i, out at once
    '{RowPixel, '0, '0, 12'd4095, 11'd2047, 0},      // both indexes at their top
    '{RowPixel, '0, '0, 12'd2048, 11'd1024, 255},    // c = 0, orbit pinned at zero
    '{RowPixel, '0, '0, 12'd1024, 11'd1024, 255},    // c = -1, period two
    '{RowPixel, '0, '0, 12'd0,    11'd1024, 0},      // c = -2, |z|^2 lands exactly on 4
    '{RowPixel, '0, '0, 12'd2560, 11'd1024, NoPin},  // c = 0.5, slow escape
    '{RowPixel, '0, '0, 12'd2048, 11'd2047, NoPin},
    '{RowPixel, '0, '0, 12'd1536, 11'd1536, NoPin},
    // zero cap: no iteration at all
    '{RowWrite, CfgMaxIter, '0, '0, '0, NoPin},
    '{RowPixel, '0, '0, 12'd2048, 11'd1024, 0},
    '{RowPixel, '0, '0, 12'd4095, 11'd0,    0},
    // zero step: every pixel maps to -2 - i
    '{RowWrite, CfgPixelStep, '0, '0, '0, NoPin},
    '{RowWrite, CfgMaxIter, CfgDataW'(255), '0, '0, NoPin},
    '{RowPixel, '0, '0, 12'd4095, 11'd2047, 0},
    '{RowPixel, '0, '0, 12'd0,    11'd0,    0},
    // step of 1.0: large indexes push the real part past the number range
    '{RowWrite, CfgPixelStep, CfgDataW'(StepUnit), '0, '0, NoPin},
    '{RowPixel, '0, '0, 12'd2,    11'd1,    255},    // c = 0
    '{RowPixel, '0, '0, 12'd1,    11'd1,    255},    // c = -1
    '{RowPixel, '0, '0, 12'd4095, 11'd2047, 0},      // saturated point
    '{RowPixel, '0, '0, 12'd3,    11'd1,    1},      // c = 1: z = 1 then 2
    // smallest step and smallest nonzero cap
    '{RowWrite, CfgPixelStep, CfgDataW'(1), '0, '0, NoPin},
    '{RowWrite, CfgMaxIter, CfgDataW'(1), '0, '0, NoPin},
    '{RowPixel, '0, '0, 12'd4095, 11'd2047, 0},
    // back to reset values, then writes to indexes with no register
    '{RowWrite, CfgPixelStep, CfgDataW'(StepReset), '0, '0, NoPin},
    '{RowWrite, CfgMaxIter, CfgDataW'(MaxIterReset), '0, '0, NoPin},
    '{RowWrite, CfgSpare, CfgDataW'(1), '0, '0, NoPin},
    '{RowWrite, CfgIdxLast, {CfgDataW{1'b1}}, '0, '0, NoPin},
    '{RowPixel, '0, '0, 12'd2048, 11'd1024, 255},    // registers must be untouched
    '{RowPixel, '0, '0, 12'd1536, 11'd512,  NoPin}
  };

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                out_strobe;
  out_item_t           out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // count pinned by the directed table, travels with the pixel
  int pin_count;

  // predictor copy of the registers and the running total
  logic [StepW-1:0]  step_cfg;
  logic [CountW-1:0] iter_cap;
  logic [TotW-1:0]   count_sum;

  out_item_t count_total_q [$];
  int        fail_count;
  int        stall_cycles;

  mandelbrot_escape_time u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // fixed-point predictor: signed 8.FracBits, every sum and product saturates
  // ---------------------------------------------------------------------------

  function automatic longint fx_clip(longint v);
    if (v > FxHi) return FxHi;
    if (v < FxLo) return FxLo;
    return v;
  endfunction

  // exact magnitude product, truncated toward zero, then signed and clipped
  function automatic longint fx_times(longint a, longint b);
    logic [63:0]      ma;
    logic [63:0]      mb;
    logic [ProdW-1:0] prod;
    logic [ProdW-1:0] mag;
    bit               neg;
    neg  = (a < 0) != (b < 0);
    ma   = (a < 0) ? -a : a;
    mb   = (b < 0) ? -b : b;
    prod = ProdW'(ma) * ProdW'(mb);
    mag  = prod >> FracBits;
    if (neg) begin
      if (mag > ProdW'(FxHi) + 1) return FxLo;
      return -longint'(mag);
    end
    if (mag > ProdW'(FxHi)) return FxHi;
    return longint'(mag);
  endfunction

  // index times step, aligned to FracBits fraction bits, clipped at the top
  function automatic longint index_pos(logic [ColW-1:0] idx);
    logic [63:0] p;
    p = 64'(idx) * 64'(step_cfg);
    if (FracBits >= StepFrac) p = p << (FracBits - StepFrac);
    else p = p >> (StepFrac - FracBits);
    if (p > 64'(FxHi)) return FxHi;
    return longint'(p);
  endfunction

  // iterations after which |z|^2 < 4 still holds, at most iter_cap
  function automatic logic [CountW-1:0] escape_count(logic [ColW-1:0] col, logic [RowW-1:0] row);
    longint cr, ci, zr, zi, re, im, mag2;
    int     t;
    logic [CountW-1:0] n;
    cr = fx_clip(index_pos(col) - 2 * FxUnit);
    ci = fx_clip(index_pos(ColW'(row)) - FxUnit);
    zr = 0;
    zi = 0;
    n  = '0;
    for (t = 0; t < int'(iter_cap); t++) begin
      re   = fx_clip(fx_times(zr, zr) - fx_times(zi, zi));
      im   = fx_times(fx_clip(zr + zr), zi);
      zr   = fx_clip(re + cr);
      zi   = fx_clip(im + ci);
      mag2 = fx_clip(fx_times(zr, zr) + fx_times(zi, zi));
      if (mag2 >= 4 * FxUnit) break;
      n++;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: everything is sampled at the rising edge, before the tb drives
  // ---------------------------------------------------------------------------

  initial begin
    step_cfg     = StepReset;
    iter_cap     = MaxIterReset;
    count_sum    = '0;
    fail_count   = 0;
    stall_cycles = 0;
  end

  always @(posedge clk) begin : monitor
    out_item_t         want;
    logic [CountW-1:0] n;
    bit                moved;
    if (rst_n) begin
      moved = 1'b0;
      // a result transfer is checked against the oldest prediction
      if (out_strobe) begin
        moved = 1'b1;
        if (count_total_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none, got count %0d total %0d",
                   $time, out_item.iteration_count, out_item.iteration_total);
        end else begin
          want = count_total_q.pop_front();
          if (out_item.iteration_count !== want.iteration_count) begin
            fail_count++;
            $display("%0t iteration_count mismatch: expected %0d, got %0d",
                     $time, want.iteration_count, out_item.iteration_count);
          end
          if (out_item.iteration_total !== want.iteration_total) begin
            fail_count++;
            $display("%0t iteration_total mismatch: expected %0d, got %0d",
                     $time, want.iteration_total, out_item.iteration_total);
          end
        end
      end
      // register write; indexes past the two registers are dropped
      // a pixel taken at the same edge already runs with the new value
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          CfgPixelStep: step_cfg = cfg_data[StepW-1:0];
          CfgMaxIter:   iter_cap = cfg_data[CountW-1:0];
          default: ;
        endcase
      end
      // a pixel transfer: predict its count and the new running total
      if (start && !busy) begin
        moved = 1'b1;
        n = escape_count(in_item.column_index, in_item.row_index);
        if (count_sum > TotTop - TotW'(n)) count_sum = TotTop;
        else count_sum = count_sum + TotW'(n);
        want.iteration_count = (pin_count == NoPin) ? n : CountW'(pin_count);
        want.iteration_total = count_sum;
        count_total_q.push_back(want);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // no transfer of any kind for too long means the block hung
  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (stall_cycles < StallLimit) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // present one pixel, optionally after a random idle burst, and hold it until accepted
  task automatic send_pixel(in_item_t px, int pin, bit idle);
    if (idle && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start     <= 1'b1;
    in_item   <= px;
    pin_count <= pin;
    do @(posedge clk); while (!(start && !busy));
  endtask

  // stop sending and let every predicted result come back; the block is idle after
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (count_total_q.size() != 0);
  endtask

  // one register transfer; valid is left high so back-to-back writes need one drive each
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  initial begin : stimulus
    in_item_t          px;
    logic [StepW-1:0]  step_val;
    logic [CountW-1:0] cap;
    int                items;
    int                i, ph, k;

    start     <= 1'b0;
    in_item   <= '0;
    pin_count <= NoPin;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (i = 0; i < PlanRows; i++) begin
      if (plan[i].kind == RowWrite) begin
        if (i == 0 || plan[i-1].kind == RowPixel) settle();
        write_reg(plan[i].idx, plan[i].value);
        if (i == PlanRows - 1 || plan[i+1].kind == RowPixel) cfg_valid <= 1'b0;
      end else begin
        px.column_index = plan[i].col;
        px.row_index    = plan[i].row;
        send_pixel(px, plan[i].pin, 1'b1);
      end
    end

    // random phases, each with its own register setting; the last runs without gaps
    for (ph = 0; ph < Phases; ph++) begin
      items = PhaseItems;
      case (ph)
        0: begin
          step_val = StepUnit;              // step of 1.0, most points saturate
          cap      = MaxIterReset;
        end
        1: begin
          step_val = StepW'(1);             // smallest nonzero step
          cap      = CountW'($urandom_range(1, 40));
        end
        2: begin
          step_val = StepReset;             // full image at full cap, kept short
          cap      = MaxIterReset;
          items    = DeepItems;
        end
        3: begin
          step_val = '0;                    // zero step and zero cap together
          cap      = '0;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) step_val = {1'($urandom), 32'($urandom)};
          else step_val = StepW'($urandom_range(1 << 20, 1 << 23));
          cap = CountW'($urandom_range(1, 48));
        end
      endcase
      settle();
      write_reg(CfgPixelStep, CfgDataW'(step_val));
      // upper data bits are noise and must be dropped
      write_reg(CfgMaxIter, {25'($urandom), cap});
      if ($urandom_range(0, 2) == 0)
        write_reg(CfgIdxW'($urandom_range(int'(CfgMaxIter) + 1, IdxTop)),
                  {1'($urandom), 32'($urandom)});
      cfg_valid <= 1'b0;
      for (k = 0; k < items; k++) begin
        px.column_index = ColW'($urandom);
        px.row_index    = RowW'($urandom);
        send_pixel(px, NoPin, ph != Phases - 1);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && count_total_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
